@@ rtl/erot_pkg.sv @@
// Shared types, widths and constants for the Euler XYZ point rotation block.
// Holds the quarter-wave sine table, built at elaboration from a fixed Taylor series.
// No dependencies.
package erot_pkg;

    // Coordinate and coefficient widths.
    localparam int COORD_WIDTH    = 24;
    localparam int OUT_WIDTH      = COORD_WIDTH + 2;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int RW             = COORD_WIDTH + 8;
    localparam int PW             = RW + TRIG_W;
    localparam int SW             = PW + 1;

    // Angle and table geometry.
    localparam int ANGLE_W   = 9;
    localparam int ROM_DEPTH = 91;
    localparam int ROM_AW    = 7;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [OUT_WIDTH-1:0]   ow_t;
    typedef logic signed [RW-1:0]          rw_t;
    typedef logic signed [PW-1:0]          prod_t;
    typedef logic signed [SW-1:0]          sum_t;
    typedef logic signed [TRIG_W-1:0]      coef_t;
    typedef logic [ANGLE_W-1:0]            angle_t;
    typedef logic [ANGLE_W:0]              deg_t;
    typedef logic [ROM_AW-1:0]             rom_idx_t;
    typedef coef_t                         rom_t [0:ROM_DEPTH-1];

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_X = 2'd0,
        REG_ANGLE_Y = 2'd1,
        REG_ANGLE_Z = 2'd2,
        REG_ORTHO   = 2'd3
    } cfg_reg_t;

    // Degree landmarks used by the quadrant folding.
    localparam deg_t DEG_90  = deg_t'(90);
    localparam deg_t DEG_180 = deg_t'(180);
    localparam deg_t DEG_270 = deg_t'(270);
    localparam deg_t DEG_360 = deg_t'(360);

    localparam coef_t COEF_ONE  = coef_t'(1 << TRIG_FRAC_BITS);
    localparam coef_t COEF_ZERO = coef_t'(0);

    // Output saturation limits, held at the internal width.
    localparam rw_t OUT_MAX = rw_t'((longint'(1) <<< (OUT_WIDTH - 1)) - 1);
    localparam rw_t OUT_MIN = rw_t'(-(longint'(1) <<< (OUT_WIDTH - 1)));

    // Cosine and sine of one rotation.
    typedef struct packed {
        coef_t c;
        coef_t s;
    } coef_pair_t;

    // Latched coefficients for the three rotations.
    typedef struct packed {
        coef_pair_t rx;
        coef_pair_t ry;
        coef_pair_t rz;
    } coef_set_t;

    // Operands of one plane rotation: u and v rotate, w passes through.
    typedef struct packed {
        rw_t u;
        rw_t v;
        rw_t w;
    } lane_t;

    // Two truncating Q30 multiplications of a series term by x.
    function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // Quarter-wave sine table in Q1.15, evaluated with an eight-term series in Q2.30.
    function automatic rom_t build_rom();
        rom_t               rom;
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        for (int k = 0; k < ROM_DEPTH; k++)
        begin
            x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
            term = x;
            sum  = signed'(x);
            term = sq_step(term, x) / 64'd6;
            sum  = sum - signed'(term);
            term = sq_step(term, x) / 64'd20;
            sum  = sum + signed'(term);
            term = sq_step(term, x) / 64'd42;
            sum  = sum - signed'(term);
            term = sq_step(term, x) / 64'd72;
            sum  = sum + signed'(term);
            term = sq_step(term, x) / 64'd110;
            sum  = sum - signed'(term);
            term = sq_step(term, x) / 64'd156;
            sum  = sum + signed'(term);
            term = sq_step(term, x) / 64'd210;
            sum  = sum - signed'(term);
            if (sum < 0)
            begin
                sum = 0;
            end
            if (sum > (64'sd1 <<< 30))
            begin
                sum = 64'sd1 <<< 30;
            end
            r = (unsigned'(sum) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
            rom[k] = coef_t'(r[TRIG_W-1:0]);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Clamp an internal value to the output field range.
    function automatic ow_t sat_out(input rw_t v);
        rw_t t;
        t = v;
        if (v > OUT_MAX)
        begin
            t = OUT_MAX;
        end
        if (v < OUT_MIN)
        begin
            t = OUT_MIN;
        end
        return ow_t'(t[OUT_WIDTH-1:0]);
    endfunction

endpackage

@@ rtl/erot_if.sv @@
// Stream interfaces for the point input and the rotated point output.
// Depends on erot_pkg for the field widths.
interface erot_in_if;
    import erot_pkg::*;

    logic   valid;
    logic   ready;
    coord_t x_in;
    coord_t y_in;
    coord_t z_in;

    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface erot_out_if;
    import erot_pkg::*;

    logic valid;
    logic ready;
    ow_t  x_out;
    ow_t  y_out;
    ow_t  z_out;

    modport source (output valid, output x_out, output y_out, output z_out, input ready);
    modport sink   (input valid, input x_out, input y_out, input z_out, output ready);
endinterface

@@ rtl/erot_coeff.sv @@
// Configuration registers and the cosine/sine latch for the three rotations.
// Depends on erot_pkg for the sine table, register indexes and types.
module erot_coeff (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [erot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [erot_pkg::CFG_DATA_W-1:0] cfg_data,
    output erot_pkg::coef_set_t          coefs
);
    import erot_pkg::*;

    angle_t    angle_x_reg, angle_x_next;
    angle_t    angle_y_reg, angle_y_next;
    angle_t    angle_z_reg, angle_z_next;
    logic      ortho_reg, ortho_next;
    coef_set_t coef_reg, coef_next;
    deg_t      ax, ay, az;

    // Reduce an angle below 360 degrees; inputs stay below 720.
    function automatic deg_t wrap(input deg_t d);
        deg_t r;
        r = d;
        if (d >= DEG_360)
        begin
            r = d - DEG_360;
        end
        return r;
    endfunction

    // Sine of a whole-degree angle below 360, folded onto the quarter-wave table.
    function automatic coef_t sine_deg(input deg_t d);
        deg_t  idx;
        logic  neg;
        coef_t v;
        idx = d;
        neg = 1'b0;
        if (d <= DEG_90)
        begin
            idx = d;
        end
        else if (d <= DEG_180)
        begin
            idx = DEG_180 - d;
        end
        else if (d <= DEG_270)
        begin
            idx = d - DEG_180;
            neg = 1'b1;
        end
        else
        begin
            idx = DEG_360 - d;
            neg = 1'b1;
        end
        v = SINE_ROM[idx[ROM_AW-1:0]];
        return neg ? -v : v;
    endfunction

    function automatic coef_pair_t trig_of(input deg_t a);
        coef_pair_t p;
        p.c = sine_deg(wrap(a + DEG_90));
        p.s = sine_deg(a);
        return p;
    endfunction

    // Register writes; bits above each register's width are dropped.
    always_comb
    begin
        angle_x_next = angle_x_reg;
        angle_y_next = angle_y_reg;
        angle_z_next = angle_z_reg;
        ortho_next   = ortho_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ANGLE_X: angle_x_next = cfg_data[ANGLE_W-1:0];
                REG_ANGLE_Y: angle_y_next = cfg_data[ANGLE_W-1:0];
                REG_ANGLE_Z: angle_z_next = cfg_data[ANGLE_W-1:0];
                REG_ORTHO:   ortho_next   = cfg_data[0];
                default:     ortho_next   = ortho_reg;
            endcase
        end
    end

    // Effective angles: ortho mode forces 90, 0, 0.
    always_comb
    begin
        if (ortho_reg)
        begin
            ax = DEG_90;
            ay = '0;
            az = '0;
        end
        else
        begin
            ax = wrap({1'b0, angle_x_reg});
            ay = wrap({1'b0, angle_y_reg});
            az = wrap({1'b0, angle_z_reg});
        end
        coef_next.rx = trig_of(ax);
        coef_next.ry = trig_of(ay);
        coef_next.rz = trig_of(az);
    end

    // The coefficient latch is registered from the angle and ortho registers, so it follows a write after them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg  <= '0;
            angle_y_reg  <= '0;
            angle_z_reg  <= '0;
            ortho_reg    <= 1'b0;
            coef_reg.rx  <= '{c: COEF_ONE, s: COEF_ZERO};
            coef_reg.ry  <= '{c: COEF_ONE, s: COEF_ZERO};
            coef_reg.rz  <= '{c: COEF_ONE, s: COEF_ZERO};
        end
        else
        begin
            angle_x_reg <= angle_x_next;
            angle_y_reg <= angle_y_next;
            angle_z_reg <= angle_z_next;
            ortho_reg   <= ortho_next;
            coef_reg    <= coef_next;
        end
    end

    assign coefs = coef_reg;

endmodule

@@ rtl/erot_stage.sv @@
// One plane rotation: u' = u*c - v*s, v' = u*s + v*c, w passes through.
// Two register stages (products, then rounded sums). Depends on erot_pkg.
module erot_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  erot_pkg::lane_t      in_lane,
    input  erot_pkg::coef_pair_t coef,
    output logic                 out_valid,
    input  logic                 out_ready,
    output erot_pkg::lane_t      out_lane
);
    import erot_pkg::*;

    logic  mul_valid_reg;
    prod_t uc_reg, vs_reg, us_reg, vc_reg;
    rw_t   mw_reg;
    logic  sum_valid_reg;
    lane_t res_reg;
    logic  adv_mul, adv_sum;
    sum_t  sum_u, sum_v;

    // A stage moves when it is empty or its successor takes its beat.
    assign adv_sum  = !sum_valid_reg || out_ready;
    assign adv_mul  = !mul_valid_reg || adv_sum;
    assign in_ready = adv_mul;

    // Round to nearest, ties upward: floor((sum + half) / 2^F).
    function automatic rw_t round_q(input sum_t s);
        sum_t t;
        t = s + (sum_t'(1) <<< (TRIG_FRAC_BITS - 1));
        t = t >>> TRIG_FRAC_BITS;
        return rw_t'(t[RW-1:0]);
    endfunction

    assign sum_u = sum_t'(uc_reg) - sum_t'(vs_reg);
    assign sum_v = sum_t'(us_reg) + sum_t'(vc_reg);

    // Valid bits of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_mul)
            begin
                mul_valid_reg <= in_valid;
            end
            if (adv_sum)
            begin
                sum_valid_reg <= mul_valid_reg;
            end
        end
    end

    // Product stage and rounded sum stage.
    always_ff @(posedge clk)
    begin
        if (adv_mul && in_valid)
        begin
            uc_reg <= prod_t'(in_lane.u) * prod_t'(coef.c);
            vs_reg <= prod_t'(in_lane.v) * prod_t'(coef.s);
            us_reg <= prod_t'(in_lane.u) * prod_t'(coef.s);
            vc_reg <= prod_t'(in_lane.v) * prod_t'(coef.c);
            mw_reg <= in_lane.w;
        end
        if (adv_sum && mul_valid_reg)
        begin
            res_reg.u <= round_q(sum_u);
            res_reg.v <= round_q(sum_v);
            res_reg.w <= mw_reg;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_lane  = res_reg;

endmodule

@@ rtl/euler_xyz_point_rotation.sv @@
// Top level of the Euler XYZ point rotation block.
// Depends on erot_pkg, erot_if, erot_coeff and erot_stage.
//
// Usage:
//   Points enter on the point channel (x_in, y_in, z_in, signed Q15.8) and the
//   rotated points leave on the rotated channel (x_out, y_out, z_out, signed
//   Q17.8, saturated). A beat moves when valid and ready are both high.
//   The point is rotated about X, then Y, then Z by the configured whole-degree
//   angles; ortho mode forces 90, 0 and 0 degrees.
//   Configuration is written through cfg_we, cfg_index and cfg_data while no
//   beat is in flight; the coefficient register follows the angle registers.
// Pipeline:
//   An accepted input beat reaches its output beat through two register stages
//   per rotation (multiply, then round) and one saturating output register.
//   One beat is accepted every cycle while the receiver keeps ready high; each
//   rotation uses four 32x17 multipliers of its own.
// Reset:
//   rst_n clears all valid bits and sets the angles and ortho mode to zero, so
//   the coefficients become cosine one and sine zero.
// Backpressure:
//   When the receiver holds ready low, the output register keeps its beat and
//   the stages behind it fill their empty slots before input ready falls.
module euler_xyz_point_rotation (
    input  logic                            clk,
    input  logic                            rst_n,
    erot_in_if.sink                         point,
    erot_out_if.source                      rotated,
    input  logic                            cfg_we,
    input  logic [erot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [erot_pkg::CFG_DATA_W-1:0] cfg_data
);
    import erot_pkg::*;

    coef_set_t coefs;
    lane_t     lane_x_in, lane_x_out;
    lane_t     lane_y_in, lane_y_out;
    lane_t     lane_z_in, lane_z_out;
    logic      vx, vy, vz;
    logic      ry, rz, rout;
    logic      out_valid_reg;
    ow_t       x_out_reg, y_out_reg, z_out_reg;

    erot_coeff u_coeff (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    // Rotation about X: y and z rotate, x passes through.
    assign lane_x_in.u = rw_t'(point.y_in);
    assign lane_x_in.v = rw_t'(point.z_in);
    assign lane_x_in.w = rw_t'(point.x_in);

    erot_stage u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_ready  (point.ready),
        .in_lane   (lane_x_in),
        .coef      (coefs.rx),
        .out_valid (vx),
        .out_ready (ry),
        .out_lane  (lane_x_out)
    );

    // Rotation about Y: z' = z*c - x*s and x' = z*s + x*c.
    assign lane_y_in.u = lane_x_out.v;
    assign lane_y_in.v = lane_x_out.w;
    assign lane_y_in.w = lane_x_out.u;

    erot_stage u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vx),
        .in_ready  (ry),
        .in_lane   (lane_y_in),
        .coef      (coefs.ry),
        .out_valid (vy),
        .out_ready (rz),
        .out_lane  (lane_y_out)
    );

    // Rotation about Z: x and y rotate, z passes through.
    assign lane_z_in.u = lane_y_out.v;
    assign lane_z_in.v = lane_y_out.w;
    assign lane_z_in.w = lane_y_out.u;

    erot_stage u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vy),
        .in_ready  (rz),
        .in_lane   (lane_z_in),
        .coef      (coefs.rz),
        .out_valid (vz),
        .out_ready (rout),
        .out_lane  (lane_z_out)
    );

    // Saturating output register.
    assign rout = !out_valid_reg || rotated.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rout)
        begin
            out_valid_reg <= vz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rout && vz)
        begin
            x_out_reg <= sat_out(lane_z_out.u);
            y_out_reg <= sat_out(lane_z_out.v);
            z_out_reg <= sat_out(lane_z_out.w);
        end
    end

    assign rotated.valid = out_valid_reg;
    assign rotated.x_out = x_out_reg;
    assign rotated.y_out = y_out_reg;
    assign rotated.z_out = z_out_reg;

endmodule
